FILE: hdl/e64stv_pkg.sv
// Shared types and constants for the ELF64 segment table validator.
// No dependencies; used by e64stv_check and elf64_segment_table_validator.
`default_nettype none

package e64stv_pkg;

	localparam int unsigned AddrWidth  = 64;
	localparam int unsigned WordWidth  = 32;
	localparam int unsigned CountWidth = 16;

	localparam logic [WordWidth-1:0]  PtLoad       = 32'd1;
	localparam logic [WordWidth-1:0]  FlagsAllowed = 32'd7;
	localparam logic [CountWidth-1:0] CountMax     = 16'hFFFF;
	localparam logic [AddrWidth-1:0]  LowAddrInit  = {AddrWidth{1'b1}};
	localparam logic [AddrWidth-1:0]  HighEndInit  = '0;

	// Outcome of checking one entry.
	typedef struct packed {
		logic                 pass;
		logic [AddrWidth-1:0] end_addr;
	} chk_t;

endpackage

`default_nettype wire

FILE: hdl/e64stv_check.sv
// Combinational per-entry checks of one ELF64 program header.
// Depends on e64stv_pkg for widths, constants and the chk_t result type.
`default_nettype none

module e64stv_check (
	input  wire logic [e64stv_pkg::WordWidth-1:0] segment_type,
	input  wire logic [e64stv_pkg::WordWidth-1:0] segment_flags,
	input  wire logic [e64stv_pkg::AddrWidth-1:0] file_offset,
	input  wire logic [e64stv_pkg::AddrWidth-1:0] virt_addr,
	input  wire logic [e64stv_pkg::AddrWidth-1:0] file_size,
	input  wire logic [e64stv_pkg::AddrWidth-1:0] mem_size,
	input  wire logic [e64stv_pkg::AddrWidth-1:0] align_bytes,
	output e64stv_pkg::chk_t                      chk
);

	logic [e64stv_pkg::AddrWidth:0]   end_sum;
	logic [e64stv_pkg::AddrWidth-1:0] align_mask;
	logic                             align_ok;

	always_comb begin
		end_sum    = {1'b0, virt_addr} + {1'b0, mem_size};
		align_mask = align_bytes - {{(e64stv_pkg::AddrWidth-1){1'b0}}, 1'b1};
		// Alignment of 0 or 1 imposes nothing; otherwise power of two and congruent.
		align_ok   = (align_bytes <= {{(e64stv_pkg::AddrWidth-1){1'b0}}, 1'b1}) ||
			(((align_bytes & align_mask) == '0) &&
			 (((file_offset ^ virt_addr) & align_mask) == '0));
		chk.pass     = (segment_type == e64stv_pkg::PtLoad) &&
			((segment_flags & ~e64stv_pkg::FlagsAllowed) == '0) &&
			(file_size <= mem_size) &&
			!end_sum[e64stv_pkg::AddrWidth] &&
			align_ok;
		chk.end_addr = end_sum[e64stv_pkg::AddrWidth-1:0];
	end

endmodule

`default_nettype wire

FILE: hdl/elf64_segment_table_validator.sv
// Top level of the ELF64 segment table validator: input register, entry check,
// running totals and result register. Depends on e64stv_pkg and e64stv_check.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one decoded program header entry
//   per transaction; last_entry marks the end of a table. Output channel
//   (out_valid/out_ready) carries one verdict with totals per table.
//   Throughput: one entry per cycle when not stalled, set by the single check
//   stage between the input register and the result register.
//   The verdict is registered as the last entry leaves the input register.
//   Stalls: entries that are not last always drain, so a stalled receiver only
//   holds back a last entry waiting in the input register, and from there the
//   input channel; the result register holds its transaction until taken.
//   Reset: arst_n clears all valids, the failure flag and the count, and sets
//   the lowest address to all ones and the highest end to zero. The totals
//   return to that state after each table's last entry.
//   An entry after a failure in the same table has no effect on the totals.
`default_nettype none

module elf64_segment_table_validator (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output      logic                                   in_ready,
	input  wire logic [e64stv_pkg::WordWidth-1:0]       segment_type,
	input  wire logic [e64stv_pkg::WordWidth-1:0]       segment_flags,
	input  wire logic [e64stv_pkg::AddrWidth-1:0]       file_offset,
	input  wire logic [e64stv_pkg::AddrWidth-1:0]       virt_addr,
	input  wire logic [e64stv_pkg::AddrWidth-1:0]       file_size,
	input  wire logic [e64stv_pkg::AddrWidth-1:0]       mem_size,
	input  wire logic [e64stv_pkg::AddrWidth-1:0]       align_bytes,
	input  wire logic                                   last_entry,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic                                   image_ok,
	output      logic [e64stv_pkg::CountWidth-1:0]      segment_count,
	output      logic [e64stv_pkg::AddrWidth-1:0]       lowest_address,
	output      logic [e64stv_pkg::AddrWidth-1:0]       highest_end
);

	// Input register
	logic                               valid_s1;
	logic [e64stv_pkg::WordWidth-1:0]   type_s1;
	logic [e64stv_pkg::WordWidth-1:0]   flags_s1;
	logic [e64stv_pkg::AddrWidth-1:0]   offset_s1;
	logic [e64stv_pkg::AddrWidth-1:0]   vaddr_s1;
	logic [e64stv_pkg::AddrWidth-1:0]   fsize_s1;
	logic [e64stv_pkg::AddrWidth-1:0]   msize_s1;
	logic [e64stv_pkg::AddrWidth-1:0]   align_s1;
	logic                               last_s1;

	// Running totals
	logic                               failed_q;
	logic [e64stv_pkg::CountWidth-1:0]  count_q;
	logic [e64stv_pkg::AddrWidth-1:0]   low_q;
	logic [e64stv_pkg::AddrWidth-1:0]   high_q;

	// Result register
	logic                               out_valid_q;
	logic                               ok_q;
	logic [e64stv_pkg::CountWidth-1:0]  res_count_q;
	logic [e64stv_pkg::AddrWidth-1:0]   res_low_q;
	logic [e64stv_pkg::AddrWidth-1:0]   res_high_q;

	e64stv_pkg::chk_t                   chk;
	logic                               advance;
	logic                               take;
	logic                               m_failed;
	logic [e64stv_pkg::CountWidth-1:0]  m_count;
	logic [e64stv_pkg::AddrWidth-1:0]   m_low;
	logic [e64stv_pkg::AddrWidth-1:0]   m_high;

	e64stv_check u_check (
		.segment_type  (type_s1),
		.segment_flags (flags_s1),
		.file_offset   (offset_s1),
		.virt_addr     (vaddr_s1),
		.file_size     (fsize_s1),
		.mem_size      (msize_s1),
		.align_bytes   (align_s1),
		.chk           (chk)
	);

	// Only a last entry needs room in the result register.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_comb begin
		m_failed = failed_q;
		m_count  = count_q;
		m_low    = low_q;
		m_high   = high_q;
		if (!failed_q) begin
			if (chk.pass) begin
				if (vaddr_s1 < low_q) begin
					m_low = vaddr_s1;
				end
				if (chk.end_addr > high_q) begin
					m_high = chk.end_addr;
				end
				if (count_q != e64stv_pkg::CountMax) begin
					m_count = count_q + {{(e64stv_pkg::CountWidth-1){1'b0}}, 1'b1};
				end
			end else begin
				m_failed = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_s1   <= segment_type;
			flags_s1  <= segment_flags;
			offset_s1 <= file_offset;
			vaddr_s1  <= virt_addr;
			fsize_s1  <= file_size;
			msize_s1  <= mem_size;
			align_s1  <= align_bytes;
			last_s1   <= last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			count_q  <= '0;
			low_q    <= e64stv_pkg::LowAddrInit;
			high_q   <= e64stv_pkg::HighEndInit;
		end else if (advance) begin
			if (last_s1) begin
				// Table done: restart totals for the next one.
				failed_q <= 1'b0;
				count_q  <= '0;
				low_q    <= e64stv_pkg::LowAddrInit;
				high_q   <= e64stv_pkg::HighEndInit;
			end else begin
				failed_q <= m_failed;
				count_q  <= m_count;
				low_q    <= m_low;
				high_q   <= m_high;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			ok_q        <= !m_failed && (m_count != '0);
			res_count_q <= m_count;
			res_low_q   <= m_low;
			res_high_q  <= m_high;
		end
	end

	assign out_valid      = out_valid_q;
	assign image_ok       = ok_q;
	assign segment_count  = res_count_q;
	assign lowest_address = res_low_q;
	assign highest_end    = res_high_q;

	// A passing verdict always carries at least one segment.
	a_ok_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> res_count_q != '0)
		else $error("image_ok with zero segment count");

	// Accepted segments bound the range: lowest start never above highest end.
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> res_low_q <= res_high_q)
		else $error("lowest_address above highest_end on a passing image");

	// Failure stays set until the table's last entry goes through.
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(advance && last_s1) |=> failed_q)
		else $error("failure flag dropped within a table");

	// Count never falls within a table.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && last_s1) |=> count_q >= $past(count_q))
		else $error("segment count decreased within a table");

	// A result is only produced by a last entry moving out of the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q |-> $past(advance && last_s1))
		else $error("result appeared without a last entry");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for elf64_segment_table_validator: directed program header tables and random
// tables, each verdict checked against a fixed expected verdict or a behavioral predictor.
// Depends on e64stv_pkg and the validator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [e64stv_pkg::WordWidth-1:0] seg_type;
		logic [e64stv_pkg::WordWidth-1:0] seg_flags;
		logic [e64stv_pkg::AddrWidth-1:0] offset;
		logic [e64stv_pkg::AddrWidth-1:0] vaddr;
		logic [e64stv_pkg::AddrWidth-1:0] fsize;
		logic [e64stv_pkg::AddrWidth-1:0] msize;
		logic [e64stv_pkg::AddrWidth-1:0] align;
		logic                             last;
	} entry_t;

	typedef struct packed {
		logic                              ok;
		logic [e64stv_pkg::CountWidth-1:0] count;
		logic [e64stv_pkg::AddrWidth-1:0]  low;
		logic [e64stv_pkg::AddrWidth-1:0]  high;
	} verdict_t;

	typedef struct {
		entry_t   e;
		bit       fixed;
		verdict_t v;
	} row_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [e64stv_pkg::WordWidth-1:0]  segment_type;
	logic [e64stv_pkg::WordWidth-1:0]  segment_flags;
	logic [e64stv_pkg::AddrWidth-1:0]  file_offset;
	logic [e64stv_pkg::AddrWidth-1:0]  virt_addr;
	logic [e64stv_pkg::AddrWidth-1:0]  file_size;
	logic [e64stv_pkg::AddrWidth-1:0]  mem_size;
	logic [e64stv_pkg::AddrWidth-1:0]  align_bytes;
	logic                              last_entry;
	logic                              out_valid;
	logic                              out_ready;
	logic                              image_ok;
	logic [e64stv_pkg::CountWidth-1:0] segment_count;
	logic [e64stv_pkg::AddrWidth-1:0]  lowest_address;
	logic [e64stv_pkg::AddrWidth-1:0]  highest_end;

	// Predictor state for the table in flight
	logic                              tbl_failed = 1'b0;
	logic [e64stv_pkg::CountWidth-1:0] tbl_count = '0;
	logic [e64stv_pkg::AddrWidth-1:0]  tbl_low = e64stv_pkg::LowAddrInit;
	logic [e64stv_pkg::AddrWidth-1:0]  tbl_high = e64stv_pkg::HighEndInit;

	verdict_t pending_verdicts[$];
	row_t     directed[$];
	int       errors = 0;
	int       entries_taken = 0;
	bit       no_gaps = 1'b0;
	bit       hold_request = 1'b0;
	bit       held_off = 1'b0;

	elf64_segment_table_validator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.segment_type  (segment_type),
		.segment_flags (segment_flags),
		.file_offset   (file_offset),
		.virt_addr     (virt_addr),
		.file_size     (file_size),
		.mem_size      (mem_size),
		.align_bytes   (align_bytes),
		.last_entry    (last_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.image_ok      (image_ok),
		.segment_count (segment_count),
		.lowest_address(lowest_address),
		.highest_end   (highest_end)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic bit entry_passes(input entry_t e);
		logic [e64stv_pkg::AddrWidth-1:0] mask;
		if (e.seg_type != e64stv_pkg::PtLoad)
			return 1'b0;
		if ((e.seg_flags & ~e64stv_pkg::FlagsAllowed) != '0)
			return 1'b0;
		if (e.fsize > e.msize)
			return 1'b0;
		// all ones minus msize is the highest vaddr whose end does not overflow
		if (e.vaddr > ~e.msize)
			return 1'b0;
		if (e.align > 64'd1) begin
			mask = e.align - 64'd1;
			if ((e.align & mask) != '0)
				return 1'b0;
			if (((e.offset ^ e.vaddr) & mask) != '0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Fold one entry into the running totals; returns 1 with the verdict on a last entry.
	function automatic bit table_step(input entry_t e, output verdict_t v);
		logic [e64stv_pkg::AddrWidth-1:0] seg_end;
		seg_end = e.vaddr + e.msize;
		if (!tbl_failed) begin
			if (entry_passes(e)) begin
				if (e.vaddr < tbl_low)
					tbl_low = e.vaddr;
				if (seg_end > tbl_high)
					tbl_high = seg_end;
				if (tbl_count != e64stv_pkg::CountMax)
					tbl_count = tbl_count + 1'b1;
			end else begin
				tbl_failed = 1'b1;
			end
		end
		v.ok    = !tbl_failed && (tbl_count != '0);
		v.count = tbl_count;
		v.low   = tbl_low;
		v.high  = tbl_high;
		if (!e.last)
			return 1'b0;
		tbl_failed = 1'b0;
		tbl_count  = '0;
		tbl_low    = e64stv_pkg::LowAddrInit;
		tbl_high   = e64stv_pkg::HighEndInit;
		return 1'b1;
	endfunction

	function automatic entry_t ent(input logic [e64stv_pkg::WordWidth-1:0] t,
		input logic [e64stv_pkg::WordWidth-1:0] f,
		input logic [e64stv_pkg::AddrWidth-1:0] off, input logic [e64stv_pkg::AddrWidth-1:0] va,
		input logic [e64stv_pkg::AddrWidth-1:0] fsz, input logic [e64stv_pkg::AddrWidth-1:0] msz,
		input logic [e64stv_pkg::AddrWidth-1:0] al, input int last);
		entry_t e;
		e.seg_type  = t;
		e.seg_flags = f;
		e.offset    = off;
		e.vaddr     = va;
		e.fsize     = fsz;
		e.msize     = msz;
		e.align     = al;
		e.last      = (last != 0);
		return e;
	endfunction

	function automatic verdict_t vd(input int ok, input int cnt,
		input logic [e64stv_pkg::AddrWidth-1:0] low, input logic [e64stv_pkg::AddrWidth-1:0] high);
		verdict_t v;
		v.ok    = (ok != 0);
		v.count = cnt[e64stv_pkg::CountWidth-1:0];
		v.low   = low;
		v.high  = high;
		return v;
	endfunction

	task automatic add_row(input entry_t e, input bit fixed, input verdict_t v);
		row_t r;
		r.e     = e;
		r.fixed = fixed;
		r.v     = v;
		directed.push_back(r);
	endtask

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Values of every magnitude, including ones near the top of the address space
	function automatic logic [e64stv_pkg::AddrWidth-1:0] wide_rand();
		logic [e64stv_pkg::AddrWidth-1:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return r;
			1: return r >> $urandom_range(1, 63);
			2: return ~(r >> $urandom_range(1, 63));
			default: return 64'($urandom_range(0, 65535)) << 12;
		endcase
	endfunction

	function automatic entry_t good_entry();
		entry_t                           e;
		logic [e64stv_pkg::AddrWidth-1:0] mask;
		e.seg_type  = e64stv_pkg::PtLoad;
		e.seg_flags = $urandom & e64stv_pkg::FlagsAllowed;
		e.vaddr     = wide_rand();
		e.msize     = wide_rand();
		if (e.msize > ~e.vaddr)
			e.msize = e.msize & ~e.vaddr;
		case ($urandom_range(0, 3))
			0: e.fsize = e.msize;
			1: e.fsize = '0;
			default: e.fsize = {$urandom, $urandom} & e.msize;
		endcase
		case ($urandom_range(0, 3))
			0: e.align = '0;
			1: e.align = 64'd1;
			default: e.align = 64'd1 << $urandom_range(1, 63);
		endcase
		mask = (e.align > 64'd1) ? e.align - 64'd1 : '0;
		e.offset = (wide_rand() & ~mask) | (e.vaddr & mask);
		e.last = 1'b0;
		return e;
	endfunction

	function automatic entry_t noise_entry();
		entry_t e;
		e.seg_type  = $urandom_range(0, 1) ? e64stv_pkg::PtLoad : $urandom;
		e.seg_flags = $urandom;
		e.offset    = {$urandom, $urandom};
		e.vaddr     = {$urandom, $urandom};
		e.fsize     = {$urandom, $urandom};
		e.msize     = {$urandom, $urandom};
		e.align     = wide_rand();
		e.last      = 1'b0;
		return e;
	endfunction

	// Spoil one check of an otherwise valid entry
	function automatic entry_t break_entry(input entry_t e);
		int k;
		case ($urandom_range(0, 5))
			0: e.seg_type = $urandom;
			1: e.seg_flags = $urandom | (32'd8 << $urandom_range(0, 28));
			2: begin
				if (e.msize == e64stv_pkg::LowAddrInit)
					e.msize = e.msize - 64'd1;
				e.fsize = e.msize + 64'd1;
			end
			3: begin
				if (e.vaddr == '0)
					e.vaddr = 64'd1;
				e.msize = ~e.vaddr + 64'($urandom_range(1, 1000));
			end
			4: e.align = wide_rand() | 64'd3;
			default: begin
				k = $urandom_range(1, 63);
				e.align  = 64'd1 << k;
				e.offset = e.vaddr ^ (64'd1 << $urandom_range(0, k - 1));
			end
		endcase
		return e;
	endfunction

	// Offer one transaction; valid stays up from the previous one when there is no gap.
	task automatic send_entry(input entry_t e, input int gap, input bit fixed,
		input verdict_t fixed_v);
		verdict_t v;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		segment_type  <= e.seg_type;
		segment_flags <= e.seg_flags;
		file_offset   <= e.offset;
		virt_addr     <= e.vaddr;
		file_size     <= e.fsize;
		mem_size      <= e.msize;
		align_bytes   <= e.align;
		last_entry    <= e.last;
		do @(posedge clk); while (!in_ready);
		entries_taken++;
		if (table_step(e, v))
			pending_verdicts.push_back(fixed ? fixed_v : v);
	endtask

	initial begin
		entry_t   e;
		verdict_t rejected_v;
		int       n;
		int       bad_pos;
		int       rand_items;
		bit       broken;
		bit       noisy;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		segment_type  = '0;
		segment_flags = '0;
		file_offset   = '0;
		virt_addr     = '0;
		file_size     = '0;
		mem_size      = '0;
		align_bytes   = '0;
		last_entry    = 1'b0;
		rand_items    = 0;
		rejected_v    = vd(0, 0, e64stv_pkg::LowAddrInit, e64stv_pkg::HighEndInit);

		// Single-entry tables first, then short multi-entry tables
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, 0, 0, 0, 1), 1, vd(1, 1, 0, 0));
		add_row(ent(0, 0, 0, 0, 0, 0, 0, 1), 1, rejected_v);
		add_row(ent('1, 0, 0, 0, 0, 0, 0, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, 32'h8, 0, 0, 0, 0, 0, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, '1, 0, 0, 0, 0, 0, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, e64stv_pkg::FlagsAllowed, 0, 64'h1000, 64'h10, 64'h10,
			0, 1), 1, vd(1, 1, 64'h1000, 64'h1010));
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, 64'd1, 0, 0, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, '1, '1, 0, 1), 1, vd(1, 1, 0, '1));
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, '1, 0, 64'd1, 0, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, '1, 0, 0, 0, 1), 1, vd(1, 1, '1, '1));
		add_row(ent(e64stv_pkg::PtLoad, 0, 64'd1, 0, 0, 0, 64'd1, 1), 1, vd(1, 1, 0, 0));
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, 0, 0, 64'd3, 1), 1, rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, 1, 64'h1234, 64'h5234, 64'h80, 64'h100, 64'h1000, 1), 1,
			vd(1, 1, 64'h5234, 64'h5334));
		add_row(ent(e64stv_pkg::PtLoad, 1, 64'h1234, 64'h5235, 0, 64'h100, 64'h1000, 1), 1,
			rejected_v);
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 64'h8000_0000_0000_0000, 0, 0,
			64'h8000_0000_0000_0000, 1), 1,
			vd(1, 1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, 0, 0, '1, 1), 1, rejected_v);
		// failure in the middle: later entries are ignored
		add_row(ent(e64stv_pkg::PtLoad, 5, 0, 64'h40_0000, 0, 64'h2000, 0, 0), 0, '0);
		add_row(ent(32'd2, 0, 0, 64'h10, 0, 64'h10, 0, 0), 0, '0);
		add_row(ent(e64stv_pkg::PtLoad, 0, 0, 0, 0, 64'h10, 0, 1), 0, '0);
		// failing last entry keeps the totals of the passing ones
		add_row(ent(e64stv_pkg::PtLoad, 4, 0, 64'h8000, 0, 64'h100, 0, 0), 0, '0);
		add_row(ent(e64stv_pkg::PtLoad, 6, 0, 64'h4000, 64'h10, 64'h10000, 0, 0), 0, '0);
		add_row(ent(e64stv_pkg::PtLoad, 32'h10, 0, 64'h100, 0, 64'h10, 0, 1), 0, '0);
		add_row(ent(e64stv_pkg::PtLoad, 5, 0, 64'h2000, 0, 64'h1000, 64'h1000, 0), 0, '0);
		add_row(ent(e64stv_pkg::PtLoad, 6, 0, 64'h1000, 64'h3000, 64'h3000, 0, 1), 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_entry(directed[i].e, idle_cycles(), directed[i].fixed, directed[i].v);

		while (rand_items < 1150) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			broken  = $urandom_range(0, 99) < 15;
			noisy   = $urandom_range(0, 99) < 5;
			bad_pos = $urandom_range(0, n - 1);
			no_gaps = $urandom_range(0, 9) == 0;
			for (int k = 0; k < n; k++) begin
				e = noisy ? noise_entry() : good_entry();
				if (broken && k == bad_pos)
					e = break_entry(e);
				e.last = (k == n - 1);
				rand_items++;
				if (rand_items >= 200)
					hold_request = 1'b1;
				send_entry(e, idle_cycles(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		wait (pending_verdicts.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: short and long stalls, quiet stretches, and one long hold-off
	initial begin
		int g;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request && !held_off) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6))
				@(posedge clk);
			g = $urandom_range(0, 99);
			g = (g < 40) ? 0 : (g < 85) ? $urandom_range(1, 3) :
				(g < 96) ? $urandom_range(4, 12) : $urandom_range(20, 60);
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_verdict
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict transaction with none expected");
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (image_ok !== want.ok) begin
					$error("image_ok: expected %0d, actual %0d", want.ok, image_ok);
					errors++;
				end
				if (segment_count !== want.count) begin
					$error("segment_count: expected %0d, actual %0d", want.count, segment_count);
					errors++;
				end
				if (lowest_address !== want.low) begin
					$error("lowest_address: expected %h, actual %h", want.low, lowest_address);
					errors++;
				end
				if (highest_end !== want.high) begin
					$error("highest_end: expected %h, actual %h", want.high, highest_end);
					errors++;
				end
			end
		end
	end

	initial begin
		#15ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/e64stv_pkg.sv
hdl/e64stv_check.sv
hdl/elf64_segment_table_validator.sv
tb/tb_top.sv
